// ----- rtl/etca_pkg.sv -----
// Shared constants, types and calendar helpers for the elapsed time calendar adder.
// Used by etca_div and elapsed_time_calendar_adder_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package etca_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MS_W     = 32;
    localparam int OUT_W    = DAY_W + MONTH_W + YEAR_W + HOUR_W + MINUTE_W + SECOND_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_DAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MONTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_YEAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_HOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_MINUTE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_MS     = 3'd6;

    // Divider
    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = 10;
    localparam int SHIFT_W   = 3;
    localparam int DIV_OP_W  = 2;

    // Constant divisions done by the shared unit
    localparam logic [DIV_OP_W-1:0] DIV_BY_1000 = 2'd0;
    localparam logic [DIV_OP_W-1:0] DIV_BY_60   = 2'd1;
    localparam logic [DIV_OP_W-1:0] DIV_BY_24   = 2'd2;
    localparam logic [DIV_OP_W-1:0] DIV_BY_400  = 2'd3;

    // Significant bits of each successive quotient
    localparam int SECS_W  = 23;  // up to 4294967 seconds
    localparam int MINS_W  = 17;  // up to 71583 minutes
    localparam int HOURS_W = 11;  // up to 1194 hours
    localparam int DAYS_W  = 6;   // up to 50 days
    localparam int CYC_W   = 9;   // year within the 400-year cycle

    localparam logic [YEAR_W-1:0] YEAR_MAX = {YEAR_W{1'b1}};
    localparam logic [CYC_W-1:0]  CYC_LAST = 9'd399;

    typedef struct packed {
        logic                 start;
        logic [DIV_OP_W-1:0]  op;
        logic [DIV_W-1:0]     dividend;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quot;
        logic [DIVISOR_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [DIVISOR_W-1:0] div_divisor(input logic [DIV_OP_W-1:0] op);
        logic [DIVISOR_W-1:0] d;
        case (op)
            DIV_BY_1000: d = 10'd1000;
            DIV_BY_60:   d = 10'd60;
            DIV_BY_24:   d = 10'd24;
            DIV_BY_400:  d = 10'd400;
            default:     d = '0;
        endcase
        div_divisor = d;
    endfunction

    // Rounded-up reciprocal scaled by 2^(32 + shift); exact for any 32-bit dividend
    function automatic logic [DIV_W-1:0] div_magic(input logic [DIV_OP_W-1:0] op);
        logic [DIV_W-1:0] m;
        case (op)
            DIV_BY_1000: m = 32'h1062_4DD3;
            DIV_BY_60:   m = 32'h8888_8889;
            DIV_BY_24:   m = 32'hAAAA_AAAB;
            DIV_BY_400:  m = 32'h51EB_851F;
            default:     m = '0;
        endcase
        div_magic = m;
    endfunction

    function automatic logic [SHIFT_W-1:0] div_shift(input logic [DIV_OP_W-1:0] op);
        logic [SHIFT_W-1:0] s;
        case (op)
            DIV_BY_1000: s = 3'd6;
            DIV_BY_60:   s = 3'd5;
            DIV_BY_24:   s = 3'd4;
            DIV_BY_400:  s = 3'd7;
            default:     s = '0;
        endcase
        div_shift = s;
    endfunction

    // Gregorian leap test from the year modulo 400
    function automatic logic is_leap(input logic [CYC_W-1:0] cyc);
        is_leap = (cyc[1:0] == 2'd0) && (cyc != 9'd100) && (cyc != 9'd200)
                  && (cyc != 9'd300);
    endfunction

    // Length of a month; codes outside 1..12 count as 31 days
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] mon,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        case (mon) inside
            4'd2:                                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
            default:                               len = 5'd31;
        endcase
        days_in = len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/etca_div.sv -----
// Constant divider shared by all divisions of the calendar adder: one 32x32 multiplier
// gives the quotient by a scaled reciprocal, then the remainder; depends on etca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module etca_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  etca_pkg::div_req_t     req,
    output etca_pkg::div_rsp_t     rsp
);
    import etca_pkg::*;

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_MULQ  = 3'd1;
    localparam logic [2:0] P_SHIFT = 3'd2;
    localparam logic [2:0] P_MULR  = 3'd3;
    localparam logic [2:0] P_SUB   = 3'd4;

    logic [2:0]           phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [DIV_OP_W-1:0]  op_reg, op_next;
    logic [DIV_W-1:0]     x_reg, x_next;
    logic [2*DIV_W-1:0]   prod_reg, prod_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     mul_a;
    logic [DIV_W-1:0]     mul_b;
    logic [2*DIV_W-1:0]   mul_p;

    // reciprocal product first, quotient times divisor second
    assign mul_a = (phase_reg == P_MULR) ? quot_reg : x_reg;
    assign mul_b = (phase_reg == P_MULR)
                   ? {{(DIV_W-DIVISOR_W){1'b0}}, div_divisor(op_reg)}
                   : div_magic(op_reg);
    assign mul_p = {{DIV_W{1'b0}}, mul_a} * {{DIV_W{1'b0}}, mul_b};

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            op_next    = req.op;
            x_next     = req.dividend;
            phase_next = P_MULQ;
        end
        else
        begin
            case (phase_reg)
                P_MULQ:
                begin
                    prod_next  = mul_p;
                    phase_next = P_SHIFT;
                end
                P_SHIFT:
                begin
                    quot_next  = prod_reg[2*DIV_W-1:DIV_W] >> div_shift(op_reg);
                    phase_next = P_MULR;
                end
                P_MULR:
                begin
                    prod_next  = mul_p;
                    phase_next = P_SUB;
                end
                P_SUB:
                begin
                    // remainder is below 1000, so the low bits suffice
                    rem_next   = x_reg[DIVISOR_W-1:0] - prod_reg[DIVISOR_W-1:0];
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
                default:
                    phase_next = P_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/elapsed_time_calendar_adder_core.sv -----
// Top level of the elapsed time calendar adder: configuration, sequencer, month stepper.
// Depends on etca_pkg and etca_div.
`timescale 1ns / 1ps
`default_nettype none

// Turns a free-running millisecond count into a calendar date and time. The start
// date, time and the millisecond count taken at that instant must be written through
// the configuration port while the block is idle; the block itself leaves that to the
// user. Each input item is handled alone: one shared 32x32 multiplier runs five
// divisions by constants in a row (milliseconds by 1000, seconds by 60, minutes by 60,
// hours by 24, and the start year by 400) through a scaled reciprocal. Each division
// runs in steps: reciprocal product, shift, quotient times divisor, subtract for the
// remainder, and a step in which the sequencer takes the result and handles the carry.
// Whole days are then stepped one month per cycle. s_axis_tready stays low from
// acceptance until the item reaches the result register, which is later while a
// previous result is still held. The result register lets a new item be accepted
// while the previous result still waits to be taken.

module elapsed_time_calendar_adder_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [etca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [etca_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [etca_pkg::MS_W-1:0]         s_axis_tdata,  // now_ms[31:0]
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // day[4:0], month[8:5], year[22:9], hour[27:23], minute[33:28], second[39:34]
    output      logic [etca_pkg::OUT_W-1:0]        m_axis_tdata
);
    import etca_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MS   = 3'd1;
    localparam logic [2:0] S_SEC  = 3'd2;
    localparam logic [2:0] S_MIN  = 3'd3;
    localparam logic [2:0] S_HR   = 3'd4;
    localparam logic [2:0] S_YR   = 3'd5;
    localparam logic [2:0] S_MON  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration
    logic [DAY_W-1:0]    start_day_reg;
    logic [MONTH_W-1:0]  start_month_reg;
    logic [YEAR_W-1:0]   start_year_reg;
    logic [HOUR_W-1:0]   start_hour_reg;
    logic [MINUTE_W-1:0] start_minute_reg;
    logic [SECOND_W-1:0] start_second_reg;
    logic [MS_W-1:0]     start_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_day_reg    <= DAY_W'(1);
            start_month_reg  <= MONTH_W'(1);
            start_year_reg   <= YEAR_W'(2025);
            start_hour_reg   <= '0;
            start_minute_reg <= '0;
            start_second_reg <= '0;
            start_ms_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_DAY:    start_day_reg    <= cfg_data[DAY_W-1:0];
                REG_START_MONTH:  start_month_reg  <= cfg_data[MONTH_W-1:0];
                REG_START_YEAR:   start_year_reg   <= cfg_data[YEAR_W-1:0];
                REG_START_HOUR:   start_hour_reg   <= cfg_data[HOUR_W-1:0];
                REG_START_MINUTE: start_minute_reg <= cfg_data[MINUTE_W-1:0];
                REG_START_SECOND: start_second_reg <= cfg_data[SECOND_W-1:0];
                REG_START_MS:     start_ms_reg     <= cfg_data[MS_W-1:0];
                default:          ;
            endcase
        end
    end

    // shared divider
    div_req_t req;
    div_rsp_t rsp;

    etca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [2:0]          state_reg, state_next;
    logic [SECOND_W-1:0] sec_reg, sec_next;
    logic [MINUTE_W-1:0] min_reg, min_next;
    logic [HOUR_W-1:0]   hr_reg, hr_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [MONTH_W-1:0]  mon_reg, mon_next;
    logic [YEAR_W-1:0]   yr_reg, yr_next;
    logic [CYC_W-1:0]    cyc_reg, cyc_next;
    logic [DAYS_W-1:0]   days_reg, days_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_data_reg, m_data_next;

    // carry handling after each division
    logic [SECOND_W:0]   sec_sum;
    logic                sec_wrap;
    logic [MINUTE_W:0]   min_sum;
    logic                min_wrap;
    logic [HOUR_W:0]     hr_sum;
    logic                hr_wrap;
    logic [MINS_W-1:0]   mins_q;
    logic [HOURS_W-1:0]  hours_q;
    logic [DAYS_W-1:0]   days_q;

    assign sec_sum  = {1'b0, start_second_reg} + {1'b0, rsp.rem[SECOND_W-1:0]};
    assign sec_wrap = (sec_sum >= (SECOND_W+1)'(60));
    assign min_sum  = {1'b0, start_minute_reg} + {1'b0, rsp.rem[MINUTE_W-1:0]};
    assign min_wrap = (min_sum >= (MINUTE_W+1)'(60));
    assign hr_sum   = {1'b0, start_hour_reg} + {1'b0, rsp.rem[HOUR_W-1:0]};
    assign hr_wrap  = (hr_sum >= (HOUR_W+1)'(24));
    assign mins_q   = rsp.quot[MINS_W-1:0] + MINS_W'(sec_wrap);
    assign hours_q  = rsp.quot[HOURS_W-1:0] + HOURS_W'(min_wrap);
    assign days_q   = rsp.quot[DAYS_W-1:0] + DAYS_W'(hr_wrap);

    // month stepper
    logic [DAY_W-1:0]    mon_len;
    logic [DAY_W+1:0]    day_end;
    logic [DAY_W:0]      len_p1;
    logic [DAY_W:0]      used;

    assign mon_len = days_in(mon_reg, is_leap(cyc_reg));
    assign day_end = {2'b00, day_reg} + {1'b0, days_reg};
    assign len_p1  = {1'b0, mon_len} + (DAY_W+1)'(1);
    assign used    = ({1'b0, day_reg} <= len_p1) ? (len_p1 - {1'b0, day_reg}) : '0;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hr_next      = hr_reg;
        day_next     = day_reg;
        mon_next     = mon_reg;
        yr_next      = yr_reg;
        cyc_next     = cyc_reg;
        days_next    = days_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        req.start    = 1'b0;
        req.op       = DIV_BY_1000;
        req.dividend = '0;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req.start    = 1'b1;
                    req.op       = DIV_BY_1000;
                    req.dividend = s_axis_tdata - start_ms_reg;
                    state_next   = S_MS;
                end
            end
            S_MS:
            begin
                if (rsp.done)
                begin
                    req.start    = 1'b1;
                    req.op       = DIV_BY_60;
                    req.dividend = {{(DIV_W-SECS_W){1'b0}}, rsp.quot[SECS_W-1:0]};
                    state_next   = S_SEC;
                end
            end
            S_SEC:
            begin
                if (rsp.done)
                begin
                    sec_next     = sec_wrap ? SECOND_W'(sec_sum - (SECOND_W+1)'(60))
                                            : sec_sum[SECOND_W-1:0];
                    req.start    = 1'b1;
                    req.op       = DIV_BY_60;
                    req.dividend = {{(DIV_W-MINS_W){1'b0}}, mins_q};
                    state_next   = S_MIN;
                end
            end
            S_MIN:
            begin
                if (rsp.done)
                begin
                    min_next     = min_wrap ? MINUTE_W'(min_sum - (MINUTE_W+1)'(60))
                                            : min_sum[MINUTE_W-1:0];
                    req.start    = 1'b1;
                    req.op       = DIV_BY_24;
                    req.dividend = {{(DIV_W-HOURS_W){1'b0}}, hours_q};
                    state_next   = S_HR;
                end
            end
            S_HR:
            begin
                if (rsp.done)
                begin
                    hr_next      = hr_wrap ? HOUR_W'(hr_sum - (HOUR_W+1)'(24))
                                           : hr_sum[HOUR_W-1:0];
                    days_next    = days_q;
                    // place of the start year in the leap cycle
                    req.start    = 1'b1;
                    req.op       = DIV_BY_400;
                    req.dividend = {{(DIV_W-YEAR_W){1'b0}}, start_year_reg};
                    state_next   = S_YR;
                end
            end
            S_YR:
            begin
                if (rsp.done)
                begin
                    cyc_next   = rsp.rem[CYC_W-1:0];
                    day_next   = start_day_reg;
                    mon_next   = start_month_reg;
                    yr_next    = start_year_reg;
                    state_next = S_MON;
                end
            end
            S_MON:
            begin
                if (days_reg == '0)
                    state_next = S_OUT;
                else if (day_end > {2'b00, mon_len})
                begin
                    // leave this month
                    days_next = days_reg - DAYS_W'(used);
                    day_next  = DAY_W'(1);
                    if (mon_reg >= MONTH_W'(12))
                    begin
                        mon_next = MONTH_W'(1);
                        yr_next  = yr_reg + YEAR_W'(1);
                        if (yr_reg == YEAR_MAX || cyc_reg == CYC_LAST)
                            cyc_next = '0;
                        else
                            cyc_next = cyc_reg + CYC_W'(1);
                    end
                    else
                        mon_next = mon_reg + MONTH_W'(1);
                end
                else
                begin
                    day_next  = day_end[DAY_W-1:0];
                    days_next = '0;
                end
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {sec_reg, min_reg, hr_reg, yr_reg, mon_reg, day_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hr_reg     <= hr_next;
        day_reg    <= day_next;
        mon_reg    <= mon_next;
        yr_reg     <= yr_next;
        cyc_reg    <= cyc_next;
        days_reg   <= days_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- tb/elapsed_time_calendar_adder_core_test.sv -----
// Self-checking bench for elapsed_time_calendar_adder_core: predicts the calendar date and
// time for every accepted millisecond count and scores the results in order.
// Depends on etca_pkg and the core RTL only.
`timescale 1ns / 1ps

module elapsed_time_calendar_adder_core_test;

    import etca_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam int unsigned MS_PER_DAY = 86400000;

    // Result layout, lowest field in the lowest bits
    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } stamp_t;

    class calendar_scoreboard;
        logic [DAY_W-1:0]    start_day;
        logic [MONTH_W-1:0]  start_month;
        logic [YEAR_W-1:0]   start_year;
        logic [HOUR_W-1:0]   start_hour;
        logic [MINUTE_W-1:0] start_minute;
        logic [SECOND_W-1:0] start_second;
        logic [MS_W-1:0]     start_ms;
        stamp_t              expected_dates[$];
        int unsigned         failures;

        function new();
            start_day = 1;
            start_month = 1;
            start_year = 2025;
            start_hour = 0;
            start_minute = 0;
            start_second = 0;
            start_ms = 0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_START_DAY:    start_day = val[DAY_W-1:0];
                REG_START_MONTH:  start_month = val[MONTH_W-1:0];
                REG_START_YEAR:   start_year = val[YEAR_W-1:0];
                REG_START_HOUR:   start_hour = val[HOUR_W-1:0];
                REG_START_MINUTE: start_minute = val[MINUTE_W-1:0];
                REG_START_SECOND: start_second = val[SECOND_W-1:0];
                REG_START_MS:     start_ms = val[MS_W-1:0];
                default:          ;
            endcase
        endfunction

        function int unsigned month_days(int unsigned mo, int unsigned yr);
            bit leap;
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            if (mo < 1 || mo > 12)
                return 31;
            case (mo)
                2:          return leap ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:    return 31;
            endcase
        endfunction

        function stamp_t date_after(logic [MS_W-1:0] now);
            logic [MS_W-1:0] span;
            int unsigned e, sec, mnt, hr, dy, mo, yr, len, used;
            stamp_t r;
            span = now - start_ms;
            e = span / 32'd1000;
            sec = start_second + e % 60;
            if (sec >= 60)
            begin
                sec -= 60;
                e += 60;
            end
            e /= 60;
            mnt = start_minute + e % 60;
            if (mnt >= 60)
            begin
                mnt -= 60;
                e += 60;
            end
            e /= 60;
            hr = start_hour + e % 24;
            if (hr >= 24)
            begin
                hr -= 24;
                e += 24;
            end
            e /= 24;
            dy = start_day;
            mo = start_month;
            yr = start_year;
            // Step whole days a month at a time; a bad day register still leaves on day 1
            while (e > 0)
            begin
                len = month_days(mo, yr);
                if (dy + e > len)
                begin
                    used = (dy <= len + 1) ? len + 1 - dy : 0;
                    e -= used;
                    dy = 1;
                    mo++;
                    if (mo > 12)
                    begin
                        mo = 1;
                        yr = (yr + 1) & 32'h3FFF;
                    end
                end
                else
                begin
                    dy += e;
                    e = 0;
                end
            end
            r.day = DAY_W'(dy);
            r.month = MONTH_W'(mo);
            r.year = YEAR_W'(yr);
            r.hour = HOUR_W'(hr);
            r.minute = MINUTE_W'(mnt);
            r.second = SECOND_W'(sec);
            return r;
        endfunction

        function void note_request(logic [MS_W-1:0] now);
            expected_dates.push_back(date_after(now));
        endfunction

        function void check_date(logic [OUT_W-1:0] raw);
            stamp_t got, want;
            got = raw;
            if (expected_dates.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year,
                             got.month, got.day, got.hour, got.minute, got.second);
                return;
            end
            want = expected_dates.pop_front();
            if (got.day !== want.day || got.month !== want.month || got.year !== want.year
                || got.hour !== want.hour || got.minute !== want.minute
                || got.second !== want.second)
            begin
                failures++;
                if (failures <= 10)
                    $display("date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                             want.year, want.month, want.day, want.hour, want.minute,
                             want.second, got.year, got.month, got.day, got.hour,
                             got.minute, got.second);
            end
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [MS_W-1:0]       s_axis_tdata = '0;   // now_ms[31:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // day[4:0], month[8:5], year[22:9], hour[27:23], minute[33:28], second[39:34]
    logic [OUT_W-1:0]      m_axis_tdata;

    calendar_scoreboard sb = new();
    bit                 quiet = 1'b0;
    int unsigned        cycle_count = 0;

    elapsed_time_calendar_adder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_date(m_axis_tdata);
    end

    // Result side: ready stretches broken by stall bursts, steady ready once quiet
    initial
    begin : result_sink
        int unsigned n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 40);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 17);
            end
            repeat (n) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int unsigned dy, mo, yr, hr, mi, se,
                                  input logic [MS_W-1:0] ms);
        write_reg(REG_START_DAY, dy);
        write_reg(REG_START_MONTH, mo);
        write_reg(REG_START_YEAR, yr);
        write_reg(REG_START_HOUR, hr);
        write_reg(REG_START_MINUTE, mi);
        write_reg(REG_START_SECOND, se);
        write_reg(REG_START_MS, ms);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Hold valid until the item is taken; idle a burst first now and then
    task automatic send_item(input logic [MS_W-1:0] now);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= now;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(now);
    endtask

    // Occasionally replace a sane register value with raw random bits
    function automatic logic [CFG_DATA_W-1:0] scramble(input int unsigned v);
        return ($urandom_range(0, 9) == 0) ? $urandom() : v;
    endfunction

    task automatic random_settings();
        int unsigned mo, yr, dy;
        mo = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0:       yr = $urandom_range(0, 9999);
            1:       yr = 4 * $urandom_range(0, 2499);
            2:       yr = 100 * $urandom_range(0, 99);
            default: yr = $urandom_range(1990, 2100);
        endcase
        dy = $urandom_range(1, sb.month_days(mo, yr));
        if ($urandom_range(0, 2) == 0)
            dy = sb.month_days(mo, yr);
        write_reg(REG_START_DAY, scramble(dy));
        write_reg(REG_START_MONTH, scramble(mo));
        write_reg(REG_START_YEAR, scramble(yr));
        write_reg(REG_START_HOUR, scramble($urandom_range(0, 1) ? 23 : $urandom_range(0, 23)));
        write_reg(REG_START_MINUTE, scramble($urandom_range(0, 1) ? 59 : $urandom_range(0, 59)));
        write_reg(REG_START_SECOND, scramble($urandom_range(0, 1) ? 59 : $urandom_range(0, 59)));
        write_reg(REG_START_MS, $urandom());
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, $urandom());
    endtask

    function automatic logic [MS_W-1:0] pick_now();
        logic [MS_W-1:0] base;
        base = sb.start_ms;
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return base + $urandom_range(0, 999);
            2:       return base + $urandom_range(0, 2 * MS_PER_DAY);
            3:       return base + MS_PER_DAY * $urandom_range(0, 49)
                            + 1000 * $urandom_range(0, 2);
            4:       return base - $urandom_range(1, 1000);
            default: return base + $urandom_range(0, 3600000);
        endcase
    endfunction

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: unit boundaries and the full counter span
        send_item(32'd0);
        send_item(32'd999);
        send_item(32'd1000);
        send_item(32'd59999);
        send_item(32'd60000);
        send_item(32'd3599999);
        send_item(32'd3600000);
        send_item(32'd86399999);
        send_item(32'd86400000);
        send_item(32'hFFFF_FFFF);
        s_axis_tvalid <= 1'b0;

        // Leap day reached across a counter wrap
        wait_idle();
        apply_settings(28, 2, 2024, 23, 59, 59, 32'hFFFF_FFFF);
        send_item(32'd999);
        send_item(32'd999 + MS_PER_DAY);
        s_axis_tvalid <= 1'b0;

        // Century year that is not leap
        wait_idle();
        apply_settings(28, 2, 2100, 23, 59, 59, 32'd0);
        send_item(32'd1000);
        s_axis_tvalid <= 1'b0;

        // Year 9999 rolls to 10000
        wait_idle();
        apply_settings(31, 12, 9999, 23, 59, 59, 32'd0);
        send_item(32'd1000);
        s_axis_tvalid <= 1'b0;

        // Top of the year field wraps to zero; unused index has no effect
        wait_idle();
        apply_settings(31, 12, 32'hFFFF_FFFF, 23, 59, 59, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_item(32'd1000);
        s_axis_tvalid <= 1'b0;

        // Zero day and month, time registers beyond range
        wait_idle();
        apply_settings(0, 0, 0, 31, 63, 63, 32'h8000_0000);
        send_item(32'h8000_0000);
        send_item(32'h8000_0000 + 40 * MS_PER_DAY);
        s_axis_tvalid <= 1'b0;

        // Month above twelve
        wait_idle();
        apply_settings(31, 15, 2023, 23, 59, 59, 32'd12345);
        send_item(32'd12345 + 35 * MS_PER_DAY);
        s_axis_tvalid <= 1'b0;

        // Day beyond the month length
        wait_idle();
        apply_settings(31, 2, 2023, 0, 0, 0, 32'd0);
        send_item(32'd0);
        send_item(MS_PER_DAY);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            random_settings();
            quiet = (ph == RANDOM_PHASES - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(pick_now());
            s_axis_tvalid <= 1'b0;
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
